// ===== rtl/core/spims_pkg.sv =====
// ----------------------------------------------------------------------------
// spims_pkg
// Shared types and constants for the SPI master byte shifter.
// ----------------------------------------------------------------------------
package spims_pkg;

    localparam int unsigned QP_W      = 16;
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned S_DATA_W  = 16;
    localparam int unsigned M_DATA_W  = 16;

    localparam logic REG_IDX_MODE    = 1'b0;
    localparam logic REG_IDX_QPERIOD = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_BIT   = 3'd2,
        PH_WAIT  = 3'd3,
        PH_STOP  = 3'd4
    } spims_phase_t;

    typedef struct packed {
        logic [1:0]      spi_mode;
        logic [QP_W-1:0] quarter_period;
    } spims_cfg_t;

    typedef struct packed {
        spims_phase_t    phase;
        logic [QP_W-1:0] tick_count;
        logic [1:0]      quarter_index;
        logic [2:0]      bit_index;
        logic [7:0]      tx_shift;
        logic [7:0]      rx_shift;
        logic [7:0]      pending_byte;
        logic            pending_valid;
        logic            frame_ends;
        logic            sclk;
        logic            mosi;
        logic            cs_n;
    } spims_state_t;

    typedef struct packed {
        logic       action;
        logic [7:0] tx_byte;
        logic       last_byte;
        logic       miso_level;
    } spims_item_t;

    typedef struct packed {
        logic       sclk_level;
        logic       mosi_level;
        logic       cs_n_level;
        logic [7:0] rx_byte;
        logic       rx_done;
        logic       ready_res;
    } spims_result_t;

endpackage

// ===== rtl/core/spims_apb_regs.sv =====
// ----------------------------------------------------------------------------
// spims_apb_regs
// APB register file: SPI mode and quarter period.
// ----------------------------------------------------------------------------
module spims_apb_regs
    import spims_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output spims_cfg_t        cfg
);

    logic [1:0]      mode_reg;
    logic [QP_W-1:0] qp_reg;
    logic            wr_en;
    logic            reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 2'd0;
            qp_reg   <= QP_W'(1);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_IDX_MODE:    mode_reg <= pwdata[1:0];
                REG_IDX_QPERIOD: qp_reg   <= pwdata[QP_W-1:0];
                default:         mode_reg <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_IDX_MODE:    prdata = {{(APB_DW-2){1'b0}}, mode_reg};
            REG_IDX_QPERIOD: prdata = {{(APB_DW-QP_W){1'b0}}, qp_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.spi_mode       = mode_reg;
    assign cfg.quarter_period = qp_reg;

endmodule

// ===== rtl/core/spims_step.sv =====
// ----------------------------------------------------------------------------
// spims_step
// Next-state and result logic for one tick of the pin timing machine.
// ----------------------------------------------------------------------------
module spims_step
    import spims_pkg::*;
(
    input  spims_state_t  state,
    input  spims_cfg_t    cfg,
    input  spims_item_t   item,
    output spims_state_t  state_next,
    output spims_result_t result
);

    logic            ready;
    logic            idle_lvl;
    logic            sample_lvl;
    logic            qdone;
    logic [QP_W:0]   tick_inc;
    logic [QP_W-1:0] tick_adv;
    logic [7:0]      rx_new;
    logic            rx_done;
    logic [7:0]      rx_out;
    spims_state_t    ns;

    assign idle_lvl   = cfg.spi_mode[1];
    assign sample_lvl = ~(cfg.spi_mode[1] ^ cfg.spi_mode[0]);
    assign tick_inc   = {1'b0, state.tick_count} + (QP_W+1)'(1);
    assign qdone      = tick_inc >= {1'b0, cfg.quarter_period};
    assign tick_adv   = qdone ? '0 : tick_inc[QP_W-1:0];
    assign rx_new     = {state.rx_shift[6:0], item.miso_level};

    always_comb
    begin
        ns      = state;
        rx_done = 1'b0;
        rx_out  = 8'd0;
        ready   = ~state.pending_valid & (state.phase != PH_STOP) & ~state.frame_ends;

        if (ready && item.action)
        begin
            ns.pending_byte  = item.tx_byte;
            ns.pending_valid = 1'b1;
            ns.frame_ends    = item.last_byte;
        end

        unique case (state.phase)
            PH_START:
            begin
                ns.tick_count = tick_adv;
                if (qdone)
                begin
                    if (state.quarter_index == 2'd0)
                    begin
                        ns.cs_n          = 1'b0;
                        ns.quarter_index = 2'd1;
                    end
                    else
                    begin
                        ns.tx_shift      = ns.pending_byte;
                        ns.pending_valid = 1'b0;
                        ns.bit_index     = 3'd0;
                        ns.quarter_index = 2'd0;
                        ns.tick_count    = '0;
                        ns.phase         = PH_BIT;
                    end
                end
            end
            PH_WAIT:
            begin
                if (ns.pending_valid)
                begin
                    ns.tx_shift      = ns.pending_byte;
                    ns.pending_valid = 1'b0;
                    ns.bit_index     = 3'd0;
                    ns.quarter_index = 2'd0;
                    ns.tick_count    = '0;
                    ns.phase         = PH_BIT;
                end
                else if (ns.frame_ends)
                begin
                    ns.phase         = PH_STOP;
                    ns.tick_count    = '0;
                    ns.quarter_index = 2'd0;
                end
            end
            PH_BIT:
            begin
                ns.tick_count = tick_adv;
                if (qdone)
                begin
                    unique case (state.quarter_index)
                        2'd0: ns.sclk = ~sample_lvl;
                        2'd1:
                        begin
                            ns.mosi     = state.tx_shift[7];
                            ns.tx_shift = {state.tx_shift[6:0], 1'b0};
                        end
                        2'd2: ns.sclk = sample_lvl;
                        default: ns.rx_shift = rx_new;
                    endcase

                    if (state.quarter_index != 2'd3)
                    begin
                        ns.quarter_index = state.quarter_index + 2'd1;
                    end
                    else if (state.bit_index != 3'd7)
                    begin
                        ns.bit_index     = state.bit_index + 3'd1;
                        ns.quarter_index = 2'd0;
                    end
                    else
                    begin
                        rx_done = 1'b1;
                        rx_out  = rx_new;
                        if (ns.pending_valid)
                        begin
                            ns.tx_shift      = ns.pending_byte;
                            ns.pending_valid = 1'b0;
                            ns.bit_index     = 3'd0;
                            ns.quarter_index = 2'd0;
                            ns.tick_count    = '0;
                        end
                        else if (ns.frame_ends)
                        begin
                            ns.phase         = PH_STOP;
                            ns.tick_count    = '0;
                            ns.quarter_index = 2'd0;
                        end
                        else
                        begin
                            ns.phase = PH_WAIT;
                        end
                    end
                end
            end
            PH_STOP:
            begin
                ns.tick_count = tick_adv;
                if (qdone)
                begin
                    unique case (state.quarter_index)
                        2'd0:    ns.sclk = idle_lvl;
                        2'd1:    ns.mosi = 1'b1;
                        2'd2:    ns.cs_n = 1'b1;
                        default: ns.cs_n = state.cs_n;
                    endcase

                    if (state.quarter_index != 2'd3)
                    begin
                        ns.quarter_index = state.quarter_index + 2'd1;
                    end
                    else
                    begin
                        ns.phase         = PH_IDLE;
                        ns.quarter_index = 2'd0;
                        ns.frame_ends    = 1'b0;
                    end
                end
            end
            default:
            begin
                // idle, and any unknown code
                ns.sclk  = idle_lvl;
                ns.phase = PH_IDLE;
                if (ns.pending_valid)
                begin
                    ns.phase         = PH_START;
                    ns.tick_count    = '0;
                    ns.quarter_index = 2'd0;
                end
            end
        endcase
    end

    assign state_next        = ns;
    assign result.sclk_level = ns.sclk;
    assign result.mosi_level = ns.mosi;
    assign result.cs_n_level = ns.cs_n;
    assign result.rx_byte    = rx_out;
    assign result.rx_done    = rx_done;
    assign result.ready_res  = ready;

endmodule

// ===== rtl/core/spi_master_byte_shifter.sv =====
// ----------------------------------------------------------------------------
// spi_master_byte_shifter
// SPI master, modes 0 to 3; one input item per tick, one result item per item.
// ----------------------------------------------------------------------------
//  channel   dir   handshake              payload
//  s_*       in    s_tvalid / s_tready    tdata {miso, tx_byte}, tuser action,
//                                         tlast last_byte
//  m_*       out   m_tvalid / m_tready    tdata {ready, rx_byte, cs_n, mosi, sclk},
//                                         tuser rx_done
//  apb       in    psel & penable         spi_mode @0x0, quarter_period @0x4
//
//  One item per cycle unless m_tready stalls; path: input register, then
//  step logic into the result register. State advances when an item moves
//  into the result register. Reset: idle, SCLK low, MOSI and CS_N high.
//  A stalled master side holds the result; an empty input register fills.
// ----------------------------------------------------------------------------
module spi_master_byte_shifter
    import spims_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] tx_byte, [8] miso_level
    input  logic                s_tuser,   // [0] action
    input  logic                s_tlast,

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [0] sclk, [1] mosi, [2] cs_n,
                                           // [10:3] rx_byte, [11] ready_res
    output logic                m_tuser,   // [0] rx_done

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    spims_cfg_t    cfg;
    spims_item_t   item_reg;
    logic          in_valid_reg;
    spims_state_t  state_reg;
    spims_state_t  state_next;
    spims_result_t res_next;
    spims_result_t res_reg;
    logic          out_valid_reg;
    logic          advance;

    spims_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spims_step u_step (
        .state      (state_reg),
        .cfg        (cfg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_IDLE, tick_count: '0, quarter_index: 2'd0,
                               bit_index: 3'd0, tx_shift: 8'd0, rx_shift: 8'd0,
                               pending_byte: 8'd0, pending_valid: 1'b0,
                               frame_ends: 1'b0, sclk: 1'b0, mosi: 1'b1,
                               cs_n: 1'b1};
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.action     <= s_tuser;
            item_reg.tx_byte    <= s_tdata[7:0];
            item_reg.last_byte  <= s_tlast;
            item_reg.miso_level <= s_tdata[8];
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.rx_done;
    assign m_tdata  = {{(M_DATA_W-12){1'b0}}, res_reg.ready_res, res_reg.rx_byte,
                       res_reg.cs_n_level, res_reg.mosi_level, res_reg.sclk_level};

    a_idle_cs_high : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_IDLE |-> state_reg.cs_n)
        else $error("chip select low while idle");

    a_stop_marked : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_STOP |-> state_reg.frame_ends)
        else $error("stop sequence without frame end mark");

    a_rx_done_cs : assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_next.rx_done |=> !m_tdata[2])
        else $error("byte completed with chip select high");

    a_rx_zero : assert property (@(posedge clk) disable iff (!rst_n)
        advance && !res_next.rx_done |=> m_tdata[10:3] == 8'd0)
        else $error("receive byte nonzero without done flag");

endmodule
